/* rtl/sois_pkg.sv */
// Shared constants and types of the sparse offset index engine.
package sois_pkg;

    localparam int INDEX_DEPTH_DEF = 1024;

    localparam int KEY_W    = 32;
    localparam int POS_W    = 64;
    localparam int OFFSET_W = 64;
    localparam int LEN_W    = 24;
    localparam int IVL_W    = 32;
    localparam int CMD_W    = 2;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 72;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    // Register select on paddr[3] (registers sit 8 bytes apart).
    localparam logic REG_BASE_OFFSET    = 1'b0;
    localparam logic REG_INDEX_INTERVAL = 1'b1;

endpackage

/* rtl/sparse_offset_index_engine.sv */
// Top level of the sparse offset index engine: item sequencer, append path and APB registers.
//
// One item comes in on the slave stream: tuser carries the command (append, lookup, clear),
// tdata the record offset, record length and lookup key. Every item gives exactly one
// result item on the master stream: the byte position, plus entry-added and index-full flags.
// Registers base_offset (addr 0) and index_interval (addr 8) sit on the APB port; write them
// only while no item is in flight.
// Append, clear and unknown commands pass from acceptance through the EXEC and RESULT states
// into the output register; the next item can be taken once the sequencer is back in IDLE. A
// lookup runs a binary floor search over the entry memory, one probe per cycle through its
// single registered read port, and ends early for an empty index or a key below the first
// entry. One item is in work at a time; ready returns high when the item has moved into the
// output register.
// The output register holds a finished result while the receiver stalls; the next item is
// accepted meanwhile, and its result waits in the sequencer until the register frees up.
// Reset clears entry count, log size, byte counter and the registers (index_interval to
// 4096). Entry memory is not cleared: entries are only read below the entry count, so no
// clearing pass is needed and the block is ready right after reset.
module sparse_offset_index_engine
    import sois_pkg::*;
#(
    parameter int INDEX_DEPTH = INDEX_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [63:0] record_offset, [87:64] record_length, [119:88] lookup_key
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    // Master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [63:0] position, [64] entry_added, [65] index_full, [71:66] zero
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(INDEX_DEPTH);
    localparam int CW = $clog2(INDEX_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_RESULT = 4'b1000
    } t_top_state;

    t_top_state        r_state, n_state;

    // Configuration registers
    logic [OFFSET_W-1:0] r_base_offset;
    logic [IVL_W-1:0]    r_index_interval;

    // Segment state
    logic [CW-1:0]       r_entry_count, n_entry_count;
    logic [POS_W-1:0]    r_log_size, n_log_size;
    logic [POS_W-1:0]    r_bytes_since, n_bytes_since;

    // Latched item
    logic [CMD_W-1:0]    r_cmd;
    logic [OFFSET_W-1:0] r_rec_offset;
    logic [LEN_W-1:0]    r_rec_length;
    logic [KEY_W-1:0]    r_key;

    // Pending result and output register
    logic [POS_W-1:0]    r_res_pos, n_res_pos;
    logic                r_res_added, n_res_added;
    logic                r_res_full, n_res_full;
    logic                r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;

    // Append path
    logic [KEY_W-1:0]    rel_offset;
    logic                due;
    logic                table_full;
    logic                add_entry;
    logic [POS_W-1:0]    bytes_base;
    logic [POS_W:0]      bytes_sum;

    // Memory and search wiring
    logic                wr_en;
    logic [AW-1:0]       rd_addr;
    logic [KEY_W-1:0]    rd_key;
    logic [POS_W-1:0]    rd_pos;
    logic                srch_start;
    logic                srch_done;
    logic [POS_W-1:0]    srch_pos;

    logic                accept;
    logic                cfg_wr;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);

    // APB: always ready, register chosen by paddr[3]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == REG_INDEX_INTERVAL)
                  ? {{(APB_DATA_W-IVL_W){1'b0}}, r_index_interval}
                  : r_base_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_offset    <= '0;
            r_index_interval <= IVL_W'(4096);
        end else if (cfg_wr) begin
            if (paddr[3] == REG_INDEX_INTERVAL) begin
                r_index_interval <= pwdata[IVL_W-1:0];
            end else begin
                r_base_offset <= pwdata;
            end
        end
    end

    // Append: relative offset is the low word of the offset difference.
    assign rel_offset = r_rec_offset[KEY_W-1:0] - r_base_offset[KEY_W-1:0];
    assign due        = (r_entry_count == '0) ||
                        (r_bytes_since >= {{(POS_W-IVL_W){1'b0}}, r_index_interval});
    assign table_full = (r_entry_count == CW'(INDEX_DEPTH));
    assign add_entry  = due && !table_full;
    assign bytes_base = add_entry ? '0 : r_bytes_since;
    assign bytes_sum  = {1'b0, bytes_base} + {{(POS_W+1-LEN_W){1'b0}}, r_rec_length};

    assign wr_en      = (r_state == ST_EXEC) && (r_cmd == CMD_APPEND) && add_entry;
    assign srch_start = (r_state == ST_EXEC) && (r_cmd == CMD_LOOKUP);

    always_comb begin
        n_state       = r_state;
        n_entry_count = r_entry_count;
        n_log_size    = r_log_size;
        n_bytes_since = r_bytes_since;
        n_res_pos     = r_res_pos;
        n_res_added   = r_res_added;
        n_res_full    = r_res_full;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;

        // Drop the output item once the receiver takes it.
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_res_pos   = '0;
                n_res_added = 1'b0;
                n_res_full  = 1'b0;
                n_state     = ST_RESULT;
                if (r_cmd == CMD_APPEND) begin
                    n_res_pos   = r_log_size;
                    n_res_added = add_entry;
                    n_res_full  = due && table_full;
                    if (add_entry) begin
                        n_entry_count = r_entry_count + CW'(1);
                    end
                    n_log_size    = r_log_size + {{(POS_W-LEN_W){1'b0}}, r_rec_length};
                    // Saturate the byte counter instead of wrapping.
                    n_bytes_since = bytes_sum[POS_W] ? '1 : bytes_sum[POS_W-1:0];
                end else if (r_cmd == CMD_LOOKUP) begin
                    n_state = ST_SEARCH;
                end else if (r_cmd == CMD_CLEAR) begin
                    n_entry_count = '0;
                    n_log_size    = '0;
                    n_bytes_since = '0;
                end
            end
            ST_SEARCH: begin
                if (srch_done) begin
                    n_res_pos = srch_pos;
                    n_state   = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{(M_TDATA_W-POS_W-2){1'b0}}, r_res_full, r_res_added,
                                   r_res_pos};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= '0;
            r_log_size    <= '0;
            r_bytes_since <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_entry_count <= n_entry_count;
            r_log_size    <= n_log_size;
            r_bytes_since <= n_bytes_since;
            r_out_valid   <= n_out_valid;
        end
        r_res_pos   <= n_res_pos;
        r_res_added <= n_res_added;
        r_res_full  <= n_res_full;
        r_out_data  <= n_out_data;
        if (accept) begin
            r_cmd        <= i_s_axis_tuser;
            r_rec_offset <= i_s_axis_tdata[63:0];
            r_rec_length <= i_s_axis_tdata[87:64];
            r_key        <= i_s_axis_tdata[119:88];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    sois_index_store #(
        .INDEX_DEPTH (INDEX_DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_entry_count[AW-1:0]),
        .i_wr_key  (rel_offset),
        .i_wr_pos  (r_log_size),
        .i_rd_addr (rd_addr),
        .o_rd_key  (rd_key),
        .o_rd_pos  (rd_pos)
    );

    sois_floor_search #(
        .INDEX_DEPTH (INDEX_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (srch_start),
        .i_key      (r_key),
        .i_count    (r_entry_count),
        .o_rd_addr  (rd_addr),
        .i_rd_key   (rd_key),
        .i_rd_pos   (rd_pos),
        .o_done     (srch_done),
        .o_position (srch_pos)
    );

endmodule

/* rtl/sois_index_store.sv */
// Index entry memory: key and position arrays, one write port, one registered read port.
module sois_index_store
    import sois_pkg::*;
#(
    parameter int INDEX_DEPTH = INDEX_DEPTH_DEF,
    parameter int AW          = $clog2(INDEX_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [KEY_W-1:0] i_wr_key,
    input  logic [POS_W-1:0] i_wr_pos,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [KEY_W-1:0] o_rd_key,
    output logic [POS_W-1:0] o_rd_pos
);

    logic [KEY_W-1:0] r_keys [INDEX_DEPTH];
    logic [POS_W-1:0] r_pos  [INDEX_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_keys[i_wr_addr] <= i_wr_key;
            r_pos[i_wr_addr]  <= i_wr_pos;
        end
        o_rd_key <= r_keys[i_rd_addr];
        o_rd_pos <= r_pos[i_rd_addr];
    end

endmodule

/* rtl/sois_floor_search.sv */
// Iterative binary floor search over the index entries, one probe per cycle.
module sois_floor_search
    import sois_pkg::*;
#(
    parameter int INDEX_DEPTH = INDEX_DEPTH_DEF,
    parameter int AW          = $clog2(INDEX_DEPTH),
    parameter int CW          = $clog2(INDEX_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    input  logic [CW-1:0]    i_count,
    output logic [AW-1:0]    o_rd_addr,
    input  logic [KEY_W-1:0] i_rd_key,
    input  logic [POS_W-1:0] i_rd_pos,
    output logic             o_done,
    output logic [POS_W-1:0] o_position
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FIRST = 4'b0010,
        S_PROBE = 4'b0100,
        S_POS   = 4'b1000
    } t_srch_state;

    t_srch_state      r_state, n_state;
    logic [KEY_W-1:0] r_key, n_key;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_len, n_len;
    logic [AW-1:0]    r_mid, n_mid;
    logic             r_done, n_done;
    logic [POS_W-1:0] r_position, n_position;

    logic [CW-1:0]    half;
    logic [CW-1:0]    step_lo;
    logic [CW-1:0]    step_len;
    logic [CW-1:0]    probe;
    logic [CW-1:0]    prev;

    always_comb begin
        n_state    = r_state;
        n_key      = r_key;
        n_lo       = r_lo;
        n_len      = r_len;
        n_mid      = r_mid;
        n_done     = 1'b0;
        n_position = r_position;
        o_rd_addr  = r_mid;
        half       = r_len >> 1;
        step_lo    = r_lo;
        step_len   = r_len;
        probe      = '0;
        prev       = '0;

        unique case (r_state)
            S_IDLE: begin
                o_rd_addr = '0;
                if (i_start) begin
                    n_key = i_key;
                    if (i_count == '0) begin
                        n_done     = 1'b1;
                        n_position = '0;
                    end else begin
                        n_len   = i_count;
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                // Key below the first entry: nothing to floor on.
                if (r_key < i_rd_key) begin
                    n_done     = 1'b1;
                    n_position = '0;
                    n_state    = S_IDLE;
                end else begin
                    probe     = r_len >> 1;
                    n_lo      = '0;
                    n_mid     = probe[AW-1:0];
                    o_rd_addr = probe[AW-1:0];
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                // Narrow the range, then issue the next probe or the final fetch, or finish with position zero.
                if (r_key < i_rd_key) begin
                    step_lo  = r_lo;
                    step_len = half;
                end else begin
                    step_lo  = CW'(r_mid) + CW'(1);
                    step_len = r_len - half - CW'(1);
                end
                n_lo  = step_lo;
                n_len = step_len;
                probe = step_lo + (step_len >> 1);
                prev  = step_lo - CW'(1);
                if (step_len != '0) begin
                    n_mid     = probe[AW-1:0];
                    o_rd_addr = probe[AW-1:0];
                end else if (step_lo == '0) begin
                    n_done     = 1'b1;
                    n_position = '0;
                    n_state    = S_IDLE;
                end else begin
                    o_rd_addr = prev[AW-1:0];
                    n_state   = S_POS;
                end
            end
            S_POS: begin
                n_done     = 1'b1;
                n_position = i_rd_pos;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_key      <= n_key;
        r_lo       <= n_lo;
        r_len      <= n_len;
        r_mid      <= n_mid;
        r_position <= n_position;
    end

    assign o_done     = r_done;
    assign o_position = r_position;

endmodule

/* tb/sparse_offset_index_engine_checker.sv */
// Scoreboard of the sparse offset index engine: mirrors the index, predicts and compares results.
module sparse_offset_index_engine_checker
    import sois_pkg::*;
#(
    parameter int INDEX_DEPTH = INDEX_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    input  logic                  i_s_ready,
    // [63:0] record_offset, [87:64] record_length, [119:88] lookup_key
    input  logic [S_TDATA_W-1:0]  i_s_data,
    // [1:0] command
    input  logic [CMD_W-1:0]      i_s_user,
    input  logic                  i_m_valid,
    input  logic                  i_m_ready,
    // [63:0] position, [64] entry_added, [65] index_full, [71:66] zero
    input  logic [M_TDATA_W-1:0]  i_m_data,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_full_seen
);

    typedef struct packed {
        logic [M_TDATA_W-POS_W-3:0] pad;
        logic                       full;
        logic                       added;
        logic [POS_W-1:0]           position;
    } t_reply;

    logic [KEY_W-1:0] seg_keys [INDEX_DEPTH];
    logic [POS_W-1:0] seg_pos  [INDEX_DEPTH];
    int unsigned      seg_count;
    logic [63:0]      seg_log_size;
    logic [63:0]      seg_since;
    logic [63:0]      cfg_base;
    logic [31:0]      cfg_interval;

    t_reply owed_results [$];
    int     fail_total = 0;
    int     checked_total = 0;
    int     full_total = 0;

    // Binary floor search: upper bound over the valid entries, then step back one.
    function automatic logic [POS_W-1:0] floor_position(input logic [KEY_W-1:0] key);
        int unsigned lo;
        int unsigned len;
        int unsigned half;
        int unsigned mid;
        lo  = 0;
        len = seg_count;
        if (len == 0 || key < seg_keys[0])
            return '0;
        while (len > 0) begin
            half = len / 2;
            mid  = lo + half;
            if (key < seg_keys[mid]) begin
                len = half;
            end else begin
                lo  = mid + 1;
                len = len - half - 1;
            end
        end
        if (lo == 0)
            return '0;
        return seg_pos[lo - 1];
    endfunction

    function automatic t_reply apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic [63:0] off,
                                             input logic [LEN_W-1:0] len,
                                             input logic [KEY_W-1:0] key);
        t_reply      r;
        logic [63:0] diff;
        logic [63:0] len64;
        logic [63:0] ivl64;
        logic        due;
        r     = '0;
        len64 = {40'b0, len};
        ivl64 = {32'b0, cfg_interval};
        case (cmd)
            CMD_APPEND: begin
                diff       = off - cfg_base;
                due        = (seg_count == 0) || (seg_since >= ivl64);
                r.position = seg_log_size;
                if (due) begin
                    if (seg_count < INDEX_DEPTH) begin
                        seg_keys[seg_count] = diff[KEY_W-1:0];
                        seg_pos[seg_count]  = seg_log_size;
                        seg_count++;
                        seg_since = '0;
                        r.added   = 1'b1;
                    end else begin
                        // table full: drop the entry, keep the counter running
                        r.full = 1'b1;
                    end
                end
                seg_log_size = seg_log_size + len64;
                if (len64 > ~seg_since)
                    seg_since = '1;
                else
                    seg_since = seg_since + len64;
            end
            CMD_LOOKUP: begin
                r.position = floor_position(key);
            end
            CMD_CLEAR: begin
                seg_count    = 0;
                seg_log_size = '0;
                seg_since    = '0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        t_reply fresh;
        if (!i_rst_n) begin
            seg_count    = 0;
            seg_log_size = '0;
            seg_since    = '0;
            cfg_base     = '0;
            cfg_interval = 32'd4096;
            owed_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[3] == REG_INDEX_INTERVAL)
                    cfg_interval = i_pwdata[31:0];
                else
                    cfg_base = i_pwdata;
            end
            if (i_s_valid && i_s_ready) begin
                fresh = apply_command(i_s_user, i_s_data[63:0], i_s_data[87:64],
                                      i_s_data[119:88]);
                owed_results.insert(owed_results.size(), fresh);
            end
            if (i_m_valid && i_m_ready) begin
                got = t_reply'(i_m_data);
                if (owed_results.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $time, i_m_data);
                end else begin
                    want = owed_results.pop_front();
                    checked_total++;
                    if (got.full)
                        full_total++;
                    compare_field("position", want.position, got.position);
                    compare_field("entry_added", {63'b0, want.added}, {63'b0, got.added});
                    compare_field("index_full", {63'b0, want.full}, {63'b0, got.full});
                    compare_field("padding", {58'b0, want.pad}, {58'b0, got.pad});
                end
            end
        end
        o_pending    <= owed_results.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
        o_full_seen  <= full_total;
    end

endmodule

/* tb/sparse_offset_index_engine_tb.sv */
// Testbench top of the sparse offset index engine: stimulus, stalls, config phases and verdict.
module sparse_offset_index_engine_tb;
    import sois_pkg::*;

    // no-operation command, outside the defined set
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_OFF     = 400;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_data = '0;
    logic [CMD_W-1:0]      s_user = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [M_TDATA_W-1:0]  m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int checked;
    int full_seen;

    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    int unsigned n_append = 0;
    int unsigned n_lookup = 0;
    int unsigned n_clear = 0;
    int unsigned n_other = 0;
    int unsigned n_cfg = 0;
    logic [63:0] cur_base = '0;
    logic        hold_off_armed = 1'b0;
    logic        hold_off_done = 1'b0;

    always #5 clk = ~clk;

    sparse_offset_index_engine #(
        .INDEX_DEPTH (INDEX_DEPTH_DEF)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    sparse_offset_index_engine_checker #(
        .INDEX_DEPTH (INDEX_DEPTH_DEF)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_s_user     (s_user),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_seen  (full_seen)
    );

    // Watchdog: end a hung run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stall stretches, always-ready stretches, short hold-offs,
    // and once a long hold-off so the engine backs up and drops its input ready.
    initial begin : rx_stall
        int unsigned mode;
        int unsigned span;
        int unsigned duty;
        int unsigned k;
        wait (rst_n);
        forever begin
            if (hold_off_armed && !hold_off_done) begin
                hold_off_done = 1'b1;
                for (k = 0; k < HOLD_OFF; k++) begin
                    @(posedge clk);
                    m_ready <= 1'b0;
                end
            end else begin
                mode = $urandom_range(0, 15);
                span = $urandom_range(5, 60);
                duty = $urandom_range(20, 90);
                for (k = 0; k < span; k++) begin
                    @(posedge clk);
                    if (mode < 9)
                        m_ready <= ($urandom_range(0, 99) < duty);
                    else if (mode < 14)
                        m_ready <= 1'b1;
                    else
                        m_ready <= 1'b0;
                end
            end
        end
    end

    // Offer one item and hold it until accepted; close a burst with a random gap.
    task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [63:0] off,
                             input logic [LEN_W-1:0] len, input logic [KEY_W-1:0] key);
        int unsigned gap;
        s_user  <= cmd;
        s_data  <= {key, len, off};
        s_valid <= 1'b1;
        do @(posedge clk); while (!s_ready);
        case (cmd)
            CMD_APPEND: n_append++;
            CMD_LOOKUP: n_lookup++;
            CMD_CLEAR:  n_clear++;
            default:    n_other++;
        endcase
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            // now and then run back to back across bursts
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Drop valid and wait until every result is back.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready, then back to idle.
    task automatic cfg_write(input logic sel, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        n_cfg++;
        if (sel == REG_BASE_OFFSET)
            cur_base = value;
    endtask

    task automatic run_directed();
        // lookups on an empty index
        push_item(CMD_LOOKUP, '0, '0, 32'h0);
        push_item(CMD_LOOKUP, '1, '1, 32'hFFFF_FFFF);
        // first append always adds an entry
        push_item(CMD_APPEND, 64'd100, 24'd1, '0);
        push_item(CMD_APPEND, 64'd101, 24'hFF_FFFF, '1);
        // interval passed: an entry resets the counter; zero length leaves the size alone
        push_item(CMD_APPEND, 64'd102, 24'd0, '0);
        push_item(CMD_APPEND, 64'd103, 24'd0, '0);
        // largest offset, but not due: no entry, and its length carries the counter past the interval
        push_item(CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 24'd5000, '0);
        // key below earlier ones, so keys stop ascending
        push_item(CMD_APPEND, 64'd50, 24'd4096, '0);
        // counter exactly at the interval
        push_item(CMD_APPEND, 64'd51, 24'd10, '0);
        // key below the first entry, exact hits, in between, top of range
        push_item(CMD_LOOKUP, '0, '0, 32'd99);
        push_item(CMD_LOOKUP, '0, '0, 32'd100);
        push_item(CMD_LOOKUP, '0, '0, 32'd102);
        push_item(CMD_LOOKUP, '0, '0, 32'd60);
        push_item(CMD_LOOKUP, '0, '0, 32'hFFFF_FFFF);
        push_item(CMD_NONE, '1, '1, '1);
        push_item(CMD_CLEAR, '1, '1, '1);
        // stale entries must not be seen after a clear
        push_item(CMD_LOOKUP, '0, '0, 32'd100);
        push_item(CMD_APPEND, 64'd0, 24'd1, '0);
        push_item(CMD_LOOKUP, '0, '0, 32'd0);
    endtask

    // Mostly ascending record offsets with random upper bits; lookups aimed at the keys in use.
    task automatic run_phase(input int unsigned n, input int unsigned pct_append,
                             input int unsigned pct_lookup, input int unsigned pct_clear,
                             input int unsigned len_hi);
        int unsigned i;
        int unsigned roll;
        logic [31:0] seg_start;
        logic [31:0] cursor;
        logic [31:0] key;
        logic [63:0] off;
        logic [LEN_W-1:0] len;
        push_item(CMD_CLEAR, {$urandom, $urandom}, 24'($urandom), $urandom);
        seg_start = $urandom;
        cursor    = seg_start;
        for (i = 1; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < pct_append) begin
                if ($urandom_range(0, 99) < 3) begin
                    cursor    = $urandom;
                    seg_start = cursor;
                end else begin
                    cursor = cursor + $urandom_range(1, 3);
                end
                off  = cur_base + {32'h0, cursor} + {$urandom, 32'h0};
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    len = 24'hFF_FFFF;
                else if (roll < 8)
                    len = 24'($urandom);
                else
                    len = 24'($urandom_range(1, len_hi));
                push_item(CMD_APPEND, off, len, $urandom);
            end else if (roll < pct_append + pct_lookup) begin
                if ($urandom_range(0, 99) < 15)
                    key = $urandom;
                else
                    key = seg_start + $urandom_range(0, cursor - seg_start + 4);
                push_item(CMD_LOOKUP, {$urandom, $urandom}, 24'($urandom), key);
            end else if (roll < pct_append + pct_lookup + pct_clear) begin
                push_item(CMD_CLEAR, {$urandom, $urandom}, 24'($urandom), $urandom);
                seg_start = $urandom;
                cursor    = seg_start;
            end else begin
                push_item(CMD_NONE, {$urandom, $urandom}, 24'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        run_directed();
        settle();

        // random base, moderate interval; long receiver hold-off early on
        cfg_write(REG_BASE_OFFSET, {$urandom, $urandom});
        cfg_write(REG_INDEX_INTERVAL, 64'd1000);
        hold_off_armed = 1'b1;
        run_phase(350, 60, 33, 4, 400);
        settle();

        // top base, zero interval: an entry per append until the table fills
        cfg_write(REG_BASE_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_INDEX_INTERVAL, 64'd0);
        run_phase(1250, 88, 11, 0, 2000);
        settle();

        // zero base, widest interval with long records
        cfg_write(REG_BASE_OFFSET, 64'd0);
        cfg_write(REG_INDEX_INTERVAL, 64'hFFFF_FFFF);
        run_phase(200, 80, 18, 1, 24'hFF_FFFF);
        settle();

        // random settings with frequent clears
        cfg_write(REG_BASE_OFFSET, {$urandom, $urandom});
        cfg_write(REG_INDEX_INTERVAL, {32'h0, 32'($urandom_range(1, 20000))});
        run_phase(150, 55, 30, 8, 3000);
        settle();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d appends, %0d lookups, %0d clears, %0d no-ops over %0d register writes.",
                 n_append, n_lookup, n_clear, n_other, n_cfg);
        $display("Checked %0d results, %0d with a full index, across one %0d-cycle receiver hold-off.",
                 checked, full_seen, HOLD_OFF);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/sois_pkg.sv
rtl/sois_index_store.sv
rtl/sois_floor_search.sv
rtl/sparse_offset_index_engine.sv
tb/sparse_offset_index_engine_checker.sv
tb/sparse_offset_index_engine_tb.sv
